### sv/cfe_pkg.sv
// Shared constants for the COBS frame encoder: action and status codes,
// run store geometry and configuration register map. No dependencies.
package cfe_pkg;

	localparam int RUN_MAX = 254;
	localparam int RUN_AW = 8;
	localparam int POS_W = 9;

	localparam logic [7:0] FULL_CODE = 8'hff;
	localparam logic [7:0] DELIM_BYTE = 8'h00;

	localparam logic [1:0] ACT_PUSH = 2'd0;
	localparam logic [1:0] ACT_CLOSE = 2'd1;
	localparam logic [1:0] ACT_TAKE = 2'd2;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_BUSY = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_APPEND_DELIM = 1'b0;

endpackage

### sv/cfe_if.sv
// Handshake channels of the COBS frame encoder: command in, response out.
// Depends on cfe_pkg for the action and status field widths.
interface cfe_cmd_if
	import cfe_pkg::*;
;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] data_byte;

	modport source (output valid, output action, output data_byte, input ready);
	modport sink (input valid, input action, input data_byte, output ready);
endinterface

interface cfe_rsp_if
	import cfe_pkg::*;
;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic       out_valid;
	logic [7:0] out_byte;
	logic       frame_last;

	modport source (output valid, output status, output out_valid, output out_byte,
		output frame_last, input ready);
	modport sink (input valid, input status, input out_valid, input out_byte,
		input frame_last, output ready);
endinterface

### sv/cobs_frame_encoder.sv
// COBS frame encoder: command channel in, one response per command out.
// Uses cfe_pkg and the channel interfaces in cfe_if.sv.
//
// Usage: each command item is push (a raw byte), close (end of frame) or
// take (fetch the next encoded byte). Every command yields exactly one
// response item carrying status, out_valid, out_byte and frame_last.
// Pushed bytes collect in a 254-entry run store (one synchronous RAM).
// A zero byte or a full 254-byte run queues a code byte and the run; close
// queues the final block and, if append_delimiter is set, a 0x00 delimiter.
// Push or close while queued bytes remain is refused with busy status.
// A command passes the RAM read stage, then the output register, before its
// response is valid. One command per cycle while the response side does not
// stall, bounded by the single RAM port (one write per push or one read per
// take). When the response side stalls, one more command is taken into the
// read stage; after that cmd.ready drops until the output register drains.
// Reset clears the run count, queue pointers and pipeline valids and sets
// append_delimiter; RAM contents are undefined and never read before written.
// The register is written over APB at address 0 (bit 0), a setup phase then
// an access phase, pready always high.
module cobs_frame_encoder
	import cfe_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	cfe_cmd_if.sink            cmd,
	cfe_rsp_if.source          rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	// configuration
	logic append_delim_q;
	logic reg_hit;

	// encoder state
	logic [RUN_AW-1:0] run_count_q, run_count_n;
	logic [POS_W-1:0]  drain_pos_q, drain_pos_n;
	logic [POS_W-1:0]  drain_len_q, drain_len_n;
	logic              drain_final_q, drain_final_n;
	logic              ended_full_q, ended_full_n;

	// run store
	logic [7:0]        run_store [RUN_MAX];
	logic              mem_we, mem_re;
	logic [RUN_AW-1:0] mem_raddr;

	// read stage
	logic       vld_s1;
	logic [1:0] status_s1;
	logic       ovalid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       sel_mem_s1;
	logic [7:0] rd_s1;

	// output register
	logic       out_vld_q;
	logic [1:0] out_status_q;
	logic       out_ovalid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;

	// combinational result
	logic [1:0] st_c;
	logic       ov_c;
	logic [7:0] byte_c;
	logic       last_c;
	logic       sel_mem_c;

	logic             accept, adv_s1, pending;
	logic [POS_W-1:0] rc_ext, pos_inc;
	logic             with_code;

	assign pready = 1'b1;
	assign reg_hit = (paddr[PADDR_W-1:2] == {(PADDR_W-2){REG_APPEND_DELIM}});
	assign prdata = reg_hit ? {{(PDATA_W-1){1'b0}}, append_delim_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			append_delim_q <= 1'b1;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			append_delim_q <= pwdata[0];
		end
	end

	assign adv_s1 = !out_vld_q || rsp.ready;
	assign cmd.ready = !vld_s1 || adv_s1;
	assign accept = cmd.valid && cmd.ready;
	assign pending = drain_pos_q < drain_len_q;
	assign rc_ext = {1'b0, run_count_q};
	assign pos_inc = drain_pos_q + 1'b1;
	assign with_code = !(ended_full_q && run_count_q == '0);

	always_comb begin
		run_count_n = run_count_q;
		drain_pos_n = drain_pos_q;
		drain_len_n = drain_len_q;
		drain_final_n = drain_final_q;
		ended_full_n = ended_full_q;
		st_c = STAT_OK;
		ov_c = 1'b0;
		byte_c = 8'h00;
		last_c = 1'b0;
		sel_mem_c = 1'b0;
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_raddr = drain_pos_q[RUN_AW-1:0] - 1'b1;
		unique case (cmd.action)
			ACT_PUSH: begin
				if (pending) begin
					st_c = STAT_BUSY;
				end else begin
					ended_full_n = 1'b0;
					if (cmd.data_byte == 8'h00) begin
						drain_pos_n = '0;
						drain_len_n = rc_ext + 1'b1;
						drain_final_n = 1'b0;
					end else begin
						mem_we = 1'b1;
						run_count_n = run_count_q + 1'b1;
						if (run_count_n == RUN_AW'(RUN_MAX)) begin
							drain_pos_n = '0;
							drain_len_n = POS_W'(RUN_MAX + 1);
							drain_final_n = 1'b0;
							ended_full_n = 1'b1;
						end
					end
				end
			end
			ACT_CLOSE: begin
				if (pending) begin
					st_c = STAT_BUSY;
				end else begin
					ended_full_n = 1'b0;
					drain_final_n = 1'b1;
					drain_len_n = rc_ext + 1'b1 + {{(POS_W-1){1'b0}}, append_delim_q};
					drain_pos_n = with_code ? '0 : rc_ext + 1'b1;
					// full run already sent and no delimiter: nothing to queue
					if (!with_code && !append_delim_q) begin
						drain_pos_n = '0;
						drain_len_n = '0;
						drain_final_n = 1'b0;
						run_count_n = '0;
					end
				end
			end
			ACT_TAKE: begin
				if (!pending) begin
					st_c = STAT_EMPTY;
				end else begin
					ov_c = 1'b1;
					if (drain_pos_q == '0) begin
						byte_c = (run_count_q == RUN_AW'(RUN_MAX)) ? FULL_CODE
							: run_count_q + 1'b1;
					end else if (drain_pos_q <= rc_ext) begin
						sel_mem_c = 1'b1;
						mem_re = 1'b1;
					end else begin
						byte_c = DELIM_BYTE;
					end
					drain_pos_n = pos_inc;
					if (pos_inc >= drain_len_q) begin
						last_c = drain_final_q;
						drain_pos_n = '0;
						drain_len_n = '0;
						drain_final_n = 1'b0;
						run_count_n = '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_count_q <= '0;
			drain_pos_q <= '0;
			drain_len_q <= '0;
			drain_final_q <= 1'b0;
			ended_full_q <= 1'b0;
		end else if (accept) begin
			run_count_q <= run_count_n;
			drain_pos_q <= drain_pos_n;
			drain_len_q <= drain_len_n;
			drain_final_q <= drain_final_n;
			ended_full_q <= ended_full_n;
		end
	end

	// single-port run store; writes and reads never coincide on one item
	always_ff @(posedge clk) begin
		if (accept && mem_we) begin
			run_store[run_count_q] <= cmd.data_byte;
		end
		if (accept && mem_re) begin
			rd_s1 <= run_store[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			vld_s1 <= accept || (vld_s1 && !adv_s1);
			out_vld_q <= (vld_s1 && adv_s1) || (out_vld_q && !rsp.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= st_c;
			ovalid_s1 <= ov_c;
			byte_s1 <= byte_c;
			last_s1 <= last_c;
			sel_mem_s1 <= sel_mem_c;
		end
		if (vld_s1 && adv_s1) begin
			out_status_q <= status_s1;
			out_ovalid_q <= ovalid_s1;
			out_byte_q <= sel_mem_s1 ? rd_s1 : byte_s1;
			out_last_q <= last_s1;
		end
	end

	assign rsp.valid = out_vld_q;
	assign rsp.status = out_status_q;
	assign rsp.out_valid = out_ovalid_q;
	assign rsp.out_byte = out_byte_q;
	assign rsp.frame_last = out_last_q;

endmodule

### bench/tb_cobs_frame_encoder.sv
// Testbench for cobs_frame_encoder: random and directed push/close/take items,
// responses checked against an in-bench COBS encoder model.
// Depends on cfe_pkg and the channel interfaces in cfe_if.sv.
`timescale 1ns / 1ps

module tb_cobs_frame_encoder
	import cfe_pkg::*;
;

	localparam logic [1:0] ACT_NOP = 2'd3;
	localparam logic [PADDR_W-1:0] DELIM_ADDR = PADDR_W'(4 * REG_APPEND_DELIM);
	localparam int LIMIT_CYCLES = 300000;
	localparam int LONG_HOLD_AT = 80;
	localparam int LONG_HOLD_CYCLES = 300;

	typedef struct packed {
		logic [1:0] status;
		logic       out_valid;
		logic [7:0] out_byte;
		logic       frame_last;
	} enc_rsp_t;

	class cobs_scoreboard;
		logic [7:0]         run_mem [RUN_MAX];
		logic [RUN_AW-1:0]  run_len;
		logic [POS_W-1:0]   drain_pos;
		logic [POS_W-1:0]   drain_len;
		bit                 drain_final;
		bit                 full_run_closed;
		bit                 delim_on;
		enc_rsp_t           expected_q [$];
		int unsigned        errors;

		function new();
			foreach (run_mem[i]) run_mem[i] = '0;
			run_len = '0;
			drain_pos = '0;
			drain_len = '0;
			drain_final = 0;
			full_run_closed = 0;
			delim_on = 1;
			errors = 0;
		endfunction

		function void report(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endfunction

		function bit out_pending();
			return drain_pos < drain_len;
		endfunction

		function void clear_drain();
			drain_pos = '0;
			drain_len = '0;
			drain_final = 0;
			run_len = '0;
		endfunction

		// Queue code byte (optional), run bytes and, for a closed frame, the delimiter if enabled.
		function void queue_block(bit final_blk, bit with_code);
			drain_final = final_blk;
			drain_len = POS_W'(run_len) + 1'b1;
			drain_pos = with_code ? '0 : drain_len;
			if (final_blk && delim_on)
				drain_len++;
			if (drain_pos >= drain_len)
				clear_drain();
		endfunction

		function void note_command(logic [1:0] act, logic [7:0] d);
			enc_rsp_t r;
			bit skip_code;
			r = '0;
			r.status = STAT_OK;
			case (act)
				ACT_PUSH, ACT_CLOSE: begin
					if (out_pending()) begin
						r.status = STAT_BUSY;
					end else if (act == ACT_PUSH) begin
						full_run_closed = 0;
						if (d == 8'h00) begin
							queue_block(0, 1);
						end else begin
							if (run_len < RUN_MAX)
								run_mem[run_len] = d;
							run_len++;
							if (run_len >= RUN_MAX) begin
								run_len = RUN_AW'(RUN_MAX);
								queue_block(0, 1);
								full_run_closed = 1;
							end
						end
					end else begin
						// a frame ending on a full run has already sent its last block
						skip_code = full_run_closed && run_len == 0;
						full_run_closed = 0;
						queue_block(1, !skip_code);
					end
				end
				ACT_TAKE: begin
					if (!out_pending()) begin
						r.status = STAT_EMPTY;
					end else begin
						r.out_valid = 1'b1;
						if (drain_pos == 0)
							r.out_byte = (run_len >= RUN_MAX) ? FULL_CODE : 8'(run_len + 1);
						else if (drain_pos <= run_len)
							r.out_byte = run_mem[RUN_AW'(drain_pos - 1'b1)];
						else
							r.out_byte = DELIM_BYTE;
						drain_pos++;
						if (drain_pos >= drain_len) begin
							r.frame_last = drain_final;
							clear_drain();
						end
					end
				end
				default: ;
			endcase
			expected_q.push_back(r);
		endfunction

		function void check_response(enc_rsp_t got);
			enc_rsp_t exp_r;
			if (expected_q.size() == 0) begin
				report($sformatf("response with nothing expected: %p", got));
				return;
			end
			exp_r = expected_q.pop_front();
			if (got.status !== exp_r.status || got.out_valid !== exp_r.out_valid ||
				got.out_byte !== exp_r.out_byte || got.frame_last !== exp_r.frame_last)
				report($sformatf("got %p, wanted %p", got, exp_r));
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	cfe_cmd_if cmd_ch ();
	cfe_rsp_if rsp_ch ();

	cobs_scoreboard sb = new();

	bit          quiet = 0;
	bit          calm = 0;
	int unsigned n_sent = 0;
	int unsigned rsp_seen = 0;
	int unsigned cycle_cnt = 0;

	cobs_frame_encoder u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Response side: random hold-off bursts, one long hold to fill the block.
	initial begin
		int unsigned hold_left;
		bit long_done;
		enc_rsp_t got;
		hold_left = 0;
		long_done = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				got.status = rsp_ch.status;
				got.out_valid = rsp_ch.out_valid;
				got.out_byte = rsp_ch.out_byte;
				got.frame_last = rsp_ch.frame_last;
				sb.check_response(got);
				rsp_seen++;
			end
			if (hold_left > 0) begin
				hold_left--;
			end else if (!long_done && rsp_seen >= LONG_HOLD_AT) begin
				hold_left = LONG_HOLD_CYCLES;
				long_done = 1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				hold_left = $urandom_range(1, 15);
			end
			rsp_ch.ready <= arst_n && hold_left == 0;
		end
	end

	task automatic send_cmd(input logic [1:0] act, input logic [7:0] d);
		cmd_ch.valid <= 1'b1;
		cmd_ch.action <= act;
		cmd_ch.data_byte <= d;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		sb.note_command(act, d);
		n_sent++;
		if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		data = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Call only with the block idle.
	task automatic set_delimiter(input bit on);
		logic [PDATA_W-1:0] rd;
		apb_write(DELIM_ADDR, PDATA_W'(on));
		sb.delim_on = on;
		// bus idle between the two transfers
		@(posedge clk);
		apb_read(DELIM_ADDR, rd);
		if (rd[0] !== on)
			sb.report($sformatf("append_delimiter reads %b, wrote %b", rd[0], on));
	endtask

	// Take queued bytes; now and then try a push or close that must be refused.
	task automatic drain_queue();
		while (sb.out_pending()) begin
			if ($urandom_range(0, 99) < 6)
				send_cmd($urandom_range(0, 1) ? ACT_CLOSE : ACT_PUSH, 8'($urandom));
			else
				send_cmd(ACT_TAKE, 8'($urandom));
		end
	endtask

	task automatic run_frame(input int n_bytes, input int lead_nonzero, input int zero_pct);
		logic [7:0] b;
		calm = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < n_bytes; i++) begin
			drain_queue();
			if ($urandom_range(0, 99) < 3)
				send_cmd(ACT_TAKE, 8'($urandom));
			if ($urandom_range(0, 99) < 2)
				send_cmd(ACT_NOP, 8'($urandom));
			if (i >= lead_nonzero && $urandom_range(0, 99) < zero_pct)
				b = 8'h00;
			else
				b = 8'($urandom_range(1, 255));
			send_cmd(ACT_PUSH, b);
		end
		drain_queue();
		send_cmd(ACT_CLOSE, 8'($urandom));
		drain_queue();
	endtask

	// Short frames; one frame of exactly a full run halfway through if asked.
	task automatic run_phase(input int budget, input bit with_long);
		int unsigned start;
		bit long_done;
		start = n_sent;
		long_done = !with_long;
		while (n_sent - start < budget || !long_done) begin
			if (!long_done && n_sent - start >= budget / 2) begin
				run_frame(RUN_MAX, RUN_MAX, 0);
				long_done = 1;
			end else begin
				run_frame($urandom_range(0, 12), 0, $urandom_range(5, 40));
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.action <= ACT_PUSH;
		cmd_ch.data_byte <= 8'h00;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		set_delimiter(1'b1);

		// directed: empty take, no-op, empty frame, busy refusals, extremes
		send_cmd(ACT_TAKE, 8'hff);
		send_cmd(ACT_NOP, 8'h00);
		send_cmd(ACT_CLOSE, 8'h00);
		send_cmd(ACT_TAKE, 8'h00);
		send_cmd(ACT_TAKE, 8'h00);
		send_cmd(ACT_PUSH, 8'hff);
		send_cmd(ACT_PUSH, 8'h00);
		send_cmd(ACT_PUSH, 8'h7e);
		send_cmd(ACT_CLOSE, 8'hff);
		send_cmd(ACT_TAKE, 8'h00);
		send_cmd(ACT_TAKE, 8'h00);
		send_cmd(ACT_PUSH, 8'h00);
		send_cmd(ACT_TAKE, 8'h00);
		send_cmd(ACT_PUSH, 8'h80);
		send_cmd(ACT_PUSH, 8'h01);
		send_cmd(ACT_CLOSE, 8'h00);
		repeat (4) send_cmd(ACT_TAKE, 8'h00);
		send_cmd(ACT_TAKE, 8'h00);

		run_phase(40, 0);
		wait_drained();
		set_delimiter(1'b0);
		run_phase(40, 0);
		wait_drained();
		set_delimiter(1'b1);
		run_phase(20, 1);
		wait_drained();
		set_delimiter(1'b0);
		quiet = 1;
		run_phase(40, 0);
		wait_drained();
		repeat (10) @(posedge clk);

		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
